[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// response a fixed number of cycles after the trigger
`define CHK_DELAY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("delayed response missing");

`endif

[rtl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// types, constants and tables of the polar go-to-goal controller
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int GUARD_BITS = 8;
  localparam int ANG_BITS   = 30;
  localparam int FIELD_W    = 16;
  localparam int SPEED_W    = 15;
  localparam int GAIN_W     = 16;

  // cordic datapath widths: 2^23 * sqrt2 * 1.647 stays below 2^25
  localparam int XY_W   = 27;
  localparam int Z_W    = 34;
  localparam int INVK_W = 30;
  localparam int PROD_W = XY_W + INVK_W + 1;
  localparam int DIST_SHIFT = ANG_BITS + GUARD_BITS;
  localparam int DQ_W   = PROD_W - DIST_SHIFT;
  localparam int BRG_SHIFT = ANG_BITS - FRAC_BITS;
  localparam int BRG_W  = Z_W - BRG_SHIFT;
  localparam int LP_W   = SPEED_W + GAIN_W;
  localparam int AP_W   = BRG_W + GAIN_W + 1;

  localparam logic [INVK_W-1:0] INVK_Q30 = 30'd652032874;
  localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam int DIST_MAX = 32767;

  localparam int TABLE_LEN = 20;
  localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048
  };

  // apb register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_DIST_GAIN  = 3'd0,
    REG_HEAD_GAIN  = 3'd1,
    REG_MAX_LIN    = 3'd2,
    REG_MAX_ANG    = 3'd3,
    REG_ARRIVE_THR = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] offset_x;
    logic signed [FIELD_W-1:0] offset_y;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0]        linear_speed;
    logic signed [FIELD_W-1:0] angular_speed;
    logic                      arrived;
  } out_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  distance_gain;
    logic [GAIN_W-1:0]  heading_gain;
    logic [SPEED_W-1:0] max_linear;
    logic [SPEED_W-1:0] max_angular;
    logic [SPEED_W-1:0] arrive_threshold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    distance_gain:    16'd2048,
    heading_gain:     16'd410,
    max_linear:       15'd1229,
    max_angular:      15'd2048,
    arrive_threshold: 15'd205
  };

  // one cordic pipeline slot
  typedef struct packed {
    logic                   vld;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

endpackage

[rtl/polar_p_controller_2d.sv]
// ----------------------------------------------------------------------------
// polar_p_controller_2d
// proportional go-to-goal controller: distance and bearing by cordic, then
// gained and limited linear and angular speed commands
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle, one cordic iteration per pipeline stage
// busy is low whenever out of reset; results cannot be held off downstream
// reset (synchronous, rst_n low): flushes every valid bit in the pipeline,
// loads the register defaults and drives busy high
module polar_p_controller_2d #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       start,
  output logic                       busy,
  input  ppc_pkg::in_t               in_data,
  // result channel
  output logic                       out_valid,
  output ppc_pkg::out_t              out_data,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppc_pkg::ADDR_W-1:0] paddr,
  input  logic [ppc_pkg::DATA_W-1:0] pwdata,
  output logic [ppc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ppc_pkg::*;

  cfg_t                   cfg;
  cordic_t                stg [CORDIC_STEPS+1];
  logic                   entry_vld_r;
  logic                   entry_zero_r;
  logic signed [XY_W-1:0] entry_x_r, entry_y_r, x0, y0, x_nxt, y_nxt;
  logic signed [Z_W-1:0]  entry_z_r, z_nxt;
  logic                   accept;

  // the pipeline never stalls, so only reset keeps transfers out
  assign busy   = ~rst_n;
  assign accept = start && !busy;

  ppc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // entry stage: scale offsets by the guard bits, fold the left half plane
  // onto the right by a rotation of pi
  always_comb begin
    x0 = XY_W'(in_data.offset_x) <<< GUARD_BITS;
    y0 = XY_W'(in_data.offset_y) <<< GUARD_BITS;
    if (x0 < 0) begin
      x_nxt = -x0;
      y_nxt = -y0;
      // start angle follows the sign of y before the fold
      z_nxt = (y0 >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      x_nxt = x0;
      y_nxt = y0;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= 1'b0;
    end else begin
      entry_vld_r <= accept;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    // zero vector: bearing and distance forced to zero further down
    entry_zero_r <= (x0 == 0) && (y0 == 0);
    entry_x_r    <= x_nxt;
    entry_y_r    <= y_nxt;
    entry_z_r    <= z_nxt;
  end

  assign stg[0] = '{vld: entry_vld_r, zero: entry_zero_r,
                    x: entry_x_r, y: entry_y_r, z: entry_z_r};

  // one iteration per stage, shift amount and table entry fixed per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    ppc_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .s_in  (stg[i]),
      .s_out (stg[i+1])
    );
  end

  // four stages: 1/K product, distance rounding, gains, limits
  ppc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_in      (stg[CORDIC_STEPS]),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/ppc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ppc_cfg_regs
// apb register file holding gains, limits and arrival threshold
// ----------------------------------------------------------------------------
module ppc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppc_pkg::ADDR_W-1:0] paddr,
  input  logic [ppc_pkg::DATA_W-1:0] pwdata,
  output logic [ppc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ppc_pkg::cfg_t              cfg
);
  import ppc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_DIST_GAIN:  cfg_nxt.distance_gain    = pwdata[GAIN_W-1:0];
        REG_HEAD_GAIN:  cfg_nxt.heading_gain     = pwdata[GAIN_W-1:0];
        REG_MAX_LIN:    cfg_nxt.max_linear       = pwdata[SPEED_W-1:0];
        REG_MAX_ANG:    cfg_nxt.max_angular      = pwdata[SPEED_W-1:0];
        REG_ARRIVE_THR: cfg_nxt.arrive_threshold = pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIST_GAIN:  prdata = DATA_W'(cfg_r.distance_gain);
      REG_HEAD_GAIN:  prdata = DATA_W'(cfg_r.heading_gain);
      REG_MAX_LIN:    prdata = DATA_W'(cfg_r.max_linear);
      REG_MAX_ANG:    prdata = DATA_W'(cfg_r.max_angular);
      REG_ARRIVE_THR: prdata = DATA_W'(cfg_r.arrive_threshold);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/ppc_cordic_stage.sv]
// ----------------------------------------------------------------------------
// ppc_cordic_stage
// one registered vectoring iteration: drives y towards zero
// ----------------------------------------------------------------------------
module ppc_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ppc_pkg::cordic_t s_in,
  output ppc_pkg::cordic_t s_out
);
  import ppc_pkg::*;

  localparam logic signed [Z_W-1:0] ANG =
    signed'({{(Z_W-30){1'b0}}, ATAN_Q30[STEP % TABLE_LEN]});

  logic                   vld_r;
  logic                   zero_r;
  logic signed [XY_W-1:0] x_in, y_in, xs, ys, x_nxt, y_nxt, x_r, y_r;
  logic signed [Z_W-1:0]  z_in, z_nxt, z_r;

  always_comb begin
    x_in = s_in.x;
    y_in = s_in.y;
    z_in = s_in.z;
    xs   = x_in >>> STEP;
    ys   = y_in >>> STEP;
    if (y_in > 0) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ANG;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= s_in.zero;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign s_out = '{vld: vld_r, zero: zero_r, x: x_r, y: y_r, z: z_r};

endmodule

[rtl/ppc_scale.sv]
// ----------------------------------------------------------------------------
// ppc_scale
// gain compensation, rounding, speed gains, limits and arrival check
// ----------------------------------------------------------------------------
module ppc_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  ppc_pkg::cordic_t s_in,
  input  ppc_pkg::cfg_t    cfg,
  output logic             out_valid,
  output ppc_pkg::out_t    out_data
);
  import ppc_pkg::*;

  localparam int LQ_W = LP_W + 1 - FRAC_BITS;
  localparam int AQ_W = AP_W + 1 - FRAC_BITS;
  localparam logic signed [PROD_W-1:0] DIST_HALF = PROD_W'(1) <<< (DIST_SHIFT - 1);
  localparam logic signed [Z_W-1:0]    BRG_HALF  = Z_W'(1) <<< (BRG_SHIFT - 1);
  localparam logic [LP_W:0]            LIN_HALF  = (LP_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [AP_W:0]     ANG_HALF  = (AP_W + 1)'(1) <<< (FRAC_BITS - 1);

  // stage 1: compensation product, bearing rounding
  logic                     v1_r, zero1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [BRG_W-1:0]  brg1_r;
  logic signed [Z_W-1:0]    zsum;
  logic signed [XY_W-1:0]   x_in;

  // stage 2: distance
  logic                     v2_r;
  logic [SPEED_W-1:0]       dist2_r, dist_nxt;
  logic signed [BRG_W-1:0]  brg2_r;
  logic signed [PROD_W-1:0] dsum;
  logic signed [DQ_W-1:0]   dq;

  // stage 3: gain products
  logic                     v3_r;
  logic [SPEED_W-1:0]       dist3_r;
  logic [LP_W-1:0]          lin_prod_r;
  logic signed [AP_W-1:0]   ang_prod_r;

  // stage 4: output register
  logic                     out_valid_r;
  out_t                     out_r, out_nxt;
  logic [LP_W:0]            lsum;
  logic [LQ_W-1:0]          lin_q, lin_cap;
  logic signed [AP_W:0]     asum;
  logic signed [AQ_W-1:0]   ang_q, lim, ang_cl;
  logic                     arrived;

  always_comb begin
    x_in = s_in.x;
    zsum = s_in.z + BRG_HALF;
  end

  always_comb begin
    dsum = prod_r + DIST_HALF;
    dq   = dsum[PROD_W-1:DIST_SHIFT];
    if (zero1_r || dq[DQ_W-1]) begin
      dist_nxt = '0;
    end else if (dq > DQ_W'(DIST_MAX)) begin
      dist_nxt = SPEED_W'(DIST_MAX);
    end else begin
      dist_nxt = dq[SPEED_W-1:0];
    end
  end

  always_comb begin
    lsum    = {1'b0, lin_prod_r} + LIN_HALF;
    lin_q   = lsum[LP_W:FRAC_BITS];
    lin_cap = (lin_q > LQ_W'(cfg.max_linear)) ? LQ_W'(cfg.max_linear) : lin_q;
    asum    = {ang_prod_r[AP_W-1], ang_prod_r} + ANG_HALF;
    ang_q   = asum[AP_W:FRAC_BITS];
    lim     = signed'(AQ_W'(cfg.max_angular));
    if (ang_q > lim) begin
      ang_cl = lim;
    end else if (ang_q < -lim) begin
      ang_cl = -lim;
    end else begin
      ang_cl = ang_q;
    end
    arrived = dist3_r < cfg.arrive_threshold;
    out_nxt.arrived       = arrived;
    out_nxt.linear_speed  = arrived ? '0 : lin_cap[SPEED_W-1:0];
    out_nxt.angular_speed = arrived ? '0 : ang_cl[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= s_in.vld;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    zero1_r    <= s_in.zero;
    prod_r     <= x_in * signed'({1'b0, INVK_Q30});
    brg1_r     <= zsum[Z_W-1:BRG_SHIFT];
    dist2_r    <= dist_nxt;
    brg2_r     <= zero1_r ? '0 : brg1_r;
    dist3_r    <= dist2_r;
    lin_prod_r <= dist2_r * cfg.distance_gain;
    ang_prod_r <= brg2_r * signed'({1'b0, cfg.heading_gain});
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/ppc_checker.sv]
// ----------------------------------------------------------------------------
// ppc_checker
// port-level checks of the controller's transfer timing and arrival output
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppc_checker #(
  parameter int LATENCY = 19
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input ppc_pkg::out_t out_data
);

  // every result comes from a transfer exactly one latency earlier
  `CHK_IMPLY(a_out_has_source, clk, rst_n, out_valid, $past(start && !busy, LATENCY))

  // every accepted transfer yields a result after the latency
  `CHK_DELAY(a_in_gives_out, clk, rst_n, start && !busy, LATENCY, out_valid)

  // on arrival both speed commands are zero
  `CHK_IMPLY(a_arrive_zero, clk, rst_n, out_valid && out_data.arrived, out_data.linear_speed == 0 && out_data.angular_speed == 0)

endmodule

bind polar_p_controller_2d ppc_checker #(
  .LATENCY (CORDIC_STEPS + 5)
) u_ppc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
